[rtl/lifo_stack_with_search_unit_macros.svh]
// Assertion macros shared by the stack block.
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lss_pkg.sv]
package lss_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Operation codes.
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_FIND  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_SIZE  = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] value;
    logic [3:0]               index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [3:0]               position;
    logic [4:0]               depth_now;
    logic                     last;
  } out_word_t;

  // Result word handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic busy;
    logic full;
    logic empty;
  } seq_stat_t;

endpackage

[rtl/lss_ram.sv]
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lss_seq.sv]
module lss_seq #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  lss_pkg::in_word_t              in_word,
  input  logic                           out_free,
  input  logic [lss_pkg::DATA_W-1:0]     rd_data,
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output logic [lss_pkg::DATA_W-1:0]     ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  output lss_pkg::emit_t                 emit,
  output lss_pkg::seq_stat_t             stat
);

  import lss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0]    ONE      = CW'(1);
  localparam logic [CW-1:0]    FULL_CNT = CW'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RDRES  = 6'b000100,
    S_SREAD  = 6'b001000,
    S_SCMP   = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [2:0]               op_r, op_nxt;
  logic [DATA_W-1:0]        value_r, value_nxt;
  logic [3:0]               idx_r, idx_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]            pend_pos_r, pend_pos_nxt;

  logic                     is_full;
  logic                     is_empty;
  logic                     idx_oor;
  logic                     match;
  logic [CW-1:0]            fill_dec;
  logic [CW-1:0]            fill_inc;

  // Shared compare unit: the same equality compare serves every step of a search.
  assign match    = (rd_data == value_r);
  assign is_full  = (fill_r == FULL_CNT);
  assign is_empty = (fill_r == '0);
  assign idx_oor  = ((CW + 4)'(idx_r) >= (CW + 4)'(fill_r));
  assign fill_dec = fill_r - ONE;
  assign fill_inc = fill_r + ONE;

  // Sequencer: decode, memory access and the top-down search walk.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    value_nxt    = value_r;
    idx_nxt      = idx_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_pos_nxt = pend_pos_r;

    ram_we    = 1'b0;
    ram_waddr = AW'(fill_r);
    ram_wdata = value_r;
    ram_re    = 1'b0;
    ram_raddr = '0;

    emit.valid          = 1'b0;
    emit.word.status    = ST_OK;
    emit.word.data      = '0;
    emit.word.position  = '0;
    emit.word.depth_now = 5'(fill_r);
    emit.word.last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_word.operation;
          value_nxt = in_word.value;
          idx_nxt   = in_word.index;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (op_r > OP_SIZE) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          state_nxt = S_IDLE;
          if (op_r == OP_PUSH) begin
            emit.valid     = 1'b1;
            emit.word.data = value_r;
            if (is_full) begin
              emit.word.status = ST_FULL;
            end else begin
              ram_we              = 1'b1;
              emit.word.position  = 4'(fill_r);
              emit.word.depth_now = 5'(fill_inc);
              fill_nxt            = fill_inc;
            end
          end else if (is_empty) begin
            emit.valid          = 1'b1;
            emit.word.status    = ST_EMPTY;
            emit.word.depth_now = '0;
          end else begin
            case (op_r)
              OP_POP: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(fill_dec);
                state_nxt = S_RDRES;
              end
              OP_FIND: begin
                ptr_nxt      = fill_r;
                cnt_nxt      = '0;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_SREAD;
              end
              OP_READ: begin
                if (idx_oor) begin
                  emit.valid       = 1'b1;
                  emit.word.status = ST_RANGE;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(idx_r);
                  state_nxt = S_RDRES;
                end
              end
              OP_CLEAR: begin
                emit.valid          = 1'b1;
                emit.word.depth_now = '0;
                fill_nxt            = '0;
              end
              default: begin
                // Size.
                emit.valid = 1'b1;
              end
            endcase
          end
        end
      end

      S_RDRES: begin
        if (out_free) begin
          emit.valid     = 1'b1;
          emit.word.data = rd_data;
          state_nxt      = S_IDLE;
          if (op_r == OP_POP) begin
            emit.word.position  = 4'(fill_dec);
            emit.word.depth_now = 5'(fill_dec);
            fill_nxt            = fill_dec;
          end else begin
            emit.word.position = idx_r;
          end
        end
      end

      S_SREAD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(ptr_r - ONE);
        ptr_nxt   = ptr_r - ONE;
        state_nxt = S_SCMP;
      end

      S_SCMP: begin
        // A held match goes out only once a newer one proves it is not the last.
        if (!(match && pend_vld_r && !out_free)) begin
          if (match && pend_vld_r) begin
            emit.valid         = 1'b1;
            emit.word.data     = value_r;
            emit.word.position = 4'(pend_pos_r);
            emit.word.last     = 1'b0;
          end
          if (match) begin
            pend_vld_nxt = 1'b1;
            pend_pos_nxt = AW'(ptr_r);
            cnt_nxt      = cnt_r + CNT_W'(1);
          end
          if ((ptr_r == '0) || (match && (cnt_r == LAST_CNT))) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_SREAD;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit.valid     = 1'b1;
          emit.word.data = value_r;
          state_nxt      = S_IDLE;
          if (pend_vld_r) begin
            emit.word.position = 4'(pend_pos_r);
          end else begin
            emit.word.status = ST_NOT_FOUND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; the captured word and search position are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    value_r    <= value_nxt;
    idx_r      <= idx_nxt;
    ptr_r      <= ptr_nxt;
    pend_pos_r <= pend_pos_nxt;
  end

  assign stat.busy  = (state_r != S_IDLE);
  assign stat.full  = is_full;
  assign stat.empty = is_empty;

endmodule

[rtl/lifo_stack_with_search_unit.sv]
// Results: push, clear, size and error results pass through the decode state and the output
// register; pop and read index also pass through the registered read of the stack memory.
// Flow: a new word is taken only once the sequencer is back in idle with the last one;
// a value search walks the entries top down, one memory read state and one compare state
// per entry through the shared comparator, and can be held by an output stall.
// Reset: synchronous, active low; empties the stack and the output register, memory untouched.
module lifo_stack_with_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lss_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lss_pkg::out_word_t out_word
);

  import lss_pkg::*;

  `include "lifo_stack_with_search_unit_macros.svh"

  localparam int AW = $clog2(DEPTH);

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  emit_t              emit;
  seq_stat_t          stat;
  logic               out_free;
  logic               out_valid_r;
  out_word_t          out_word_r;

  lss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lss_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .out_free  (out_free),
    .rd_data   (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .emit      (emit),
    .stat      (stat)
  );

  // A new word is taken whenever the sequencer is idle, even with a result still waiting.
  assign in_stall = stat.busy;

  // Output register: the sequencer writes it only when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_word_r <= emit.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the sequencer and the output register.
  `LSS_ASSERT_NOW(a_no_overwrite, emit.valid, out_free, "result emitted over a waiting word")
  `LSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, stat.busy, "accepted word not taken up")
  `LSS_ASSERT_NOW(a_full_status, out_valid_r && (out_word_r.status == ST_FULL), stat.full, "full status while not full")
  `LSS_ASSERT_NOW(a_partial_ok, emit.valid && !emit.word.last, emit.word.status == ST_OK, "non-final result not a match")

endmodule
